[src/cpt_pkg.sv]
// Shared types, constants and arithmetic helpers for the Clarke/Park transform chain.
// No dependencies; every other file in src imports this package.
`default_nettype none

package cpt_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int Q15_W           = 16;
  localparam int ANGLE_W         = 9;
  localparam int ANGLE_CODES     = 1 << ANGLE_W;
  localparam int BANK_W          = 8;
  localparam int SEL_W           = ANGLE_W - BANK_W;
  localparam int BANKS           = 1 << SEL_W;
  localparam int SUM_W           = SAMPLE_W + 2;
  localparam int PROD_W          = SAMPLE_W + Q15_W;
  localparam int ACC_W           = 36;
  localparam int DEF_ANGLE_STEPS = 360;
  localparam int INV_SQRT3_Q15   = 18919;
  localparam int SQRT3_HALF_Q15  = 28378;
  localparam int HALF_Q15        = 16384;
  localparam int RND_SHIFT       = 15;
  localparam int Q15_MIN         = -(1 << (Q15_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [Q15_W-1:0]    q15_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    sample_t              phase_a;
    sample_t              phase_b;
    logic [ANGLE_W-1:0]   angle_deg;
  } cpt_in_t;

  typedef struct packed {
    sample_t phase_c;
    sample_t alpha;
    sample_t beta;
    sample_t direct;
    sample_t quadrature;
    sample_t inv_alpha;
    sample_t inv_beta;
    sample_t out_a;
    sample_t out_b;
    sample_t out_c;
  } cpt_out_t;

  // Clamp to the signed sample range.
  function automatic sample_t sat_s(acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'((1 << (SAMPLE_W - 1)) - 1);
    lo = -hi - acc_t'(1);
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Round half up after dropping 15 fraction bits, then clamp.
  function automatic sample_t sat_rnd15(acc_t v);
    acc_t w;
    acc_t q;
    w = v + acc_t'(1 << (RND_SHIFT - 1));
    q = w >>> RND_SHIFT;
    return sat_s(q);
  endfunction

  // Q15 sine of a 32-bit turn fraction; evaluated at elaboration only.
  function automatic q15_t sine_q15(logic [31:0] p);
    logic [1:0]  quad;
    logic [63:0] one;
    logic [63:0] r;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    q15_t        res;
    one  = 64'd1 << 30;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    if (quad[0]) begin
      r = one - r;
    end
    z  = (r * 64'd1686629713) >> 30;
    z2 = (z * z) >> 30;
    t  = one - z2 / 64'd110;
    t  = one - ((z2 * t) >> 30) / 64'd72;
    t  = one - ((z2 * t) >> 30) / 64'd42;
    t  = one - ((z2 * t) >> 30) / 64'd20;
    t  = one - ((z2 * t) >> 30) / 64'd6;
    s  = (z * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    res = v[Q15_W-1:0];
    if (quad[1]) begin
      res = -res;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/cpt_angle_rom.sv]
// Sine/cosine lookup: two registered stages (bank read, bank select).
// Depends on cpt_pkg for the table function and widths.
`default_nettype none

module cpt_angle_rom #(
  parameter int ANGLE_STEPS = cpt_pkg::DEF_ANGLE_STEPS
) (
  input  logic                        clk,
  input  logic [1:0]                  adv,
  input  logic [cpt_pkg::ANGLE_W-1:0] angle,
  output cpt_pkg::q15_t               sn,
  output cpt_pkg::q15_t               cs
);
  import cpt_pkg::*;

  q15_t              sin_tab [ANGLE_CODES];
  q15_t              cos_tab [ANGLE_CODES];
  q15_t              sn_bank [BANKS];
  q15_t              cs_bank [BANKS];
  logic [SEL_W-1:0]  bank_sel;

  // Every input code maps to code mod ANGLE_STEPS, so wrapping is baked in.
  for (genvar k = 0; k < ANGLE_CODES; k++) begin : g_tab
    localparam int unsigned IDX = k % ANGLE_STEPS;
    localparam logic [31:0] PH  = 32'((64'(IDX) << 32) / ANGLE_STEPS);
    assign sin_tab[k] = sine_q15(PH);
    assign cos_tab[k] = sine_q15(PH + 32'h4000_0000);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int b = 0; b < BANKS; b++) begin
        sn_bank[b] <= sin_tab[{SEL_W'(b), angle[BANK_W-1:0]}];
        cs_bank[b] <= cos_tab[{SEL_W'(b), angle[BANK_W-1:0]}];
      end
      bank_sel <= angle[ANGLE_W-1:BANK_W];
    end
    if (adv[1]) begin
      sn <= sn_bank[bank_sel];
      cs <= cs_bank[bank_sel];
    end
  end

endmodule

`default_nettype wire

[src/cpt_clarke.sv]
// Forward Clarke transform in three stages: sums, scale multiply, round/clamp.
// Depends on cpt_pkg.
`default_nettype none

module cpt_clarke (
  input  logic             clk,
  input  logic [2:0]       adv,
  input  cpt_pkg::sample_t a,
  input  cpt_pkg::sample_t b,
  output cpt_pkg::sample_t c1,
  output cpt_pkg::sample_t al1,
  output cpt_pkg::sample_t be3
);
  import cpt_pkg::*;

  sum_t                     sum1;
  logic signed [SUM_W+Q15_W-1:0] prod2;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c1   <= sat_s(-acc_t'(a) - acc_t'(b));
      al1  <= a;
      sum1 <= sum_t'(a) + (sum_t'(b) <<< 1);
    end
    if (adv[1]) begin
      prod2 <= sum1 * q15_t'(INV_SQRT3_Q15);
    end
    if (adv[2]) begin
      be3 <= sat_rnd15(acc_t'(prod2));
    end
  end

endmodule

`default_nettype wire

[src/cpt_rotator.sv]
// Vector rotation: x = u*C + v*S, y = v*C - u*S, as multiply then round/clamp stage.
// Depends on cpt_pkg. Used for Park (S = sin) and inverse Park (S = -sin).
`default_nettype none

module cpt_rotator (
  input  logic             clk,
  input  logic [1:0]       adv,
  input  cpt_pkg::sample_t u,
  input  cpt_pkg::sample_t v,
  input  cpt_pkg::q15_t    cs,
  input  cpt_pkg::q15_t    sn,
  output cpt_pkg::sample_t x,
  output cpt_pkg::sample_t y
);
  import cpt_pkg::*;

  prod_t uc;
  prod_t vs;
  prod_t us;
  prod_t vc;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      uc <= u * cs;
      vs <= v * sn;
      us <= u * sn;
      vc <= v * cs;
    end
    if (adv[1]) begin
      x <= sat_rnd15(acc_t'(uc) + acc_t'(vs));
      y <= sat_rnd15(acc_t'(vc) - acc_t'(us));
    end
  end

endmodule

`default_nettype wire

[src/cpt_inv_clarke.sv]
// Inverse Clarke for phases b and c: multiply stage, then round/clamp stage.
// Depends on cpt_pkg.
`default_nettype none

module cpt_inv_clarke (
  input  logic             clk,
  input  logic [1:0]       adv,
  input  cpt_pkg::sample_t ia,
  input  cpt_pkg::sample_t ib,
  output cpt_pkg::sample_t ob,
  output cpt_pkg::sample_t oc
);
  import cpt_pkg::*;

  prod_t pa;
  prod_t pb;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pa <= ia * q15_t'(HALF_Q15);
      pb <= ib * q15_t'(SQRT3_HALF_Q15);
    end
    if (adv[1]) begin
      ob <= sat_rnd15(acc_t'(pb) - acc_t'(pa));
      oc <= sat_rnd15(-acc_t'(pa) - acc_t'(pb));
    end
  end

endmodule

`default_nettype wire

[src/clarke_park_transform_chain.sv]
// Clarke/Park transform chain with inverse transforms. Each request carries phase
// currents a and b plus an angle code; each result carries c = -a-b, alpha/beta,
// direct/quadrature, the inverse Park pair and the rebuilt three phases, all
// rounded half up and clamped to signed 16 bits. The block is a nine-stage
// pipeline: each request moves through the stage registers in order, and its
// result waits at the output port for as long as the output is stalled. One request
// can be accepted every cycle unless a stalled output has backed up to the input.
// The pipeline is built from this stage
// chain: sine/cosine bank read and select, the 1/sqrt3 multiply and round, two
// rotator multiply/round pairs (Park, then inverse Park) and the inverse Clarke
// multiply/round pair. Each stage has its own valid bit and advances whenever it
// is empty or the stage after it moves, so bubbles close up under a stalled
// output and a full pipe holds eight results behind the one waiting at the port.
// The angle code is taken modulo ANGLE_STEPS; sine and cosine come from Q1.15
// tables built at elaboration for every 9-bit code.
`default_nettype none

module clarke_park_transform_chain #(
  parameter int ANGLE_STEPS = cpt_pkg::DEF_ANGLE_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  cpt_pkg::cpt_in_t   sample,
  output logic               result_valid,
  input  logic               result_stall,
  output cpt_pkg::cpt_out_t  result
);
  import cpt_pkg::*;

  localparam int NSTG = 9;

  logic [NSTG:1]   vld;
  logic [NSTG:1]   vld_in;
  logic [NSTG+1:1] en;

  // Stage outputs of the submodules, named by the stage that registers them.
  sample_t c1;
  sample_t al1;
  sample_t be3;
  q15_t    sn2;
  q15_t    cs2;
  sample_t d5;
  sample_t q5;
  sample_t ia7;
  sample_t ib7;
  sample_t ob9;
  sample_t oc9;

  // Values carried alongside the work.
  sample_t c_pipe  [2:NSTG];
  sample_t al_pipe [2:NSTG];
  sample_t be_pipe [4:NSTG];
  sample_t d_pipe  [6:NSTG];
  sample_t q_pipe  [6:NSTG];
  sample_t ia_pipe [8:NSTG];
  sample_t ib_pipe [8:NSTG];
  q15_t    sn3;
  q15_t    cs3;
  q15_t    sn4;
  q15_t    cs4;
  q15_t    nsn5;
  q15_t    cs5;

  // Advance a stage when it is empty or the stage after it advances.
  always_comb begin
    en[NSTG+1] = !result_stall;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in       = {vld[NSTG-1:1], sample_valid};
  assign sample_stall = !en[1];
  assign result_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stages 1-3: derived phase, alpha, beta.
  cpt_clarke u_clarke (
    .clk (clk),
    .adv (en[3:1]),
    .a   (sample.phase_a),
    .b   (sample.phase_b),
    .c1  (c1),
    .al1 (al1),
    .be3 (be3)
  );

  // Stages 1-2: sine and cosine of the angle code.
  cpt_angle_rom #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_rom (
    .clk   (clk),
    .adv   (en[2:1]),
    .angle (sample.angle_deg),
    .sn    (sn2),
    .cs    (cs2)
  );

  // Stages 4-5: Park rotation.
  cpt_rotator u_park (
    .clk (clk),
    .adv (en[5:4]),
    .u   (al_pipe[3]),
    .v   (be3),
    .cs  (cs3),
    .sn  (sn3),
    .x   (d5),
    .y   (q5)
  );

  // Stages 6-7: inverse Park, the same rotator with the sine negated.
  cpt_rotator u_inv_park (
    .clk (clk),
    .adv (en[7:6]),
    .u   (d5),
    .v   (q5),
    .cs  (cs5),
    .sn  (nsn5),
    .x   (ia7),
    .y   (ib7)
  );

  // Stages 8-9: inverse Clarke.
  cpt_inv_clarke u_inv_clarke (
    .clk (clk),
    .adv (en[9:8]),
    .ia  (ia7),
    .ib  (ib7),
    .ob  (ob9),
    .oc  (oc9)
  );

  // Carry registers: hold on a stall, advance with their stage.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_pipe[2]  <= c1;
      al_pipe[2] <= al1;
    end
    for (int k = 3; k <= NSTG; k++) begin
      if (en[k]) begin
        c_pipe[k]  <= c_pipe[k-1];
        al_pipe[k] <= al_pipe[k-1];
      end
    end
    if (en[3]) begin
      sn3 <= sn2;
      cs3 <= cs2;
    end
    if (en[4]) begin
      be_pipe[4] <= be3;
      sn4        <= sn3;
      cs4        <= cs3;
    end
    for (int k = 5; k <= NSTG; k++) begin
      if (en[k]) begin
        be_pipe[k] <= be_pipe[k-1];
      end
    end
    if (en[5]) begin
      nsn5 <= -sn4;
      cs5  <= cs4;
    end
    if (en[6]) begin
      d_pipe[6] <= d5;
      q_pipe[6] <= q5;
    end
    for (int k = 7; k <= NSTG; k++) begin
      if (en[k]) begin
        d_pipe[k] <= d_pipe[k-1];
        q_pipe[k] <= q_pipe[k-1];
      end
    end
    if (en[8]) begin
      ia_pipe[8] <= ia7;
      ib_pipe[8] <= ib7;
    end
    if (en[9]) begin
      ia_pipe[9] <= ia_pipe[8];
      ib_pipe[9] <= ib_pipe[8];
    end
  end

  always_comb begin
    result.phase_c    = c_pipe[NSTG];
    result.alpha      = al_pipe[NSTG];
    result.beta       = be_pipe[NSTG];
    result.direct     = d_pipe[NSTG];
    result.quadrature = q_pipe[NSTG];
    result.inv_alpha  = ia_pipe[NSTG];
    result.inv_beta   = ib_pipe[NSTG];
    result.out_a      = ia_pipe[NSTG];
    result.out_b      = ob9;
    result.out_c      = oc9;
  end

`ifndef SYNTH
  // Input backpressure only when every stage is occupied and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> ((&vld) && result_stall))
    else $error("input stalled while the pipeline has room");

  // Items in flight change only by requests taken in and results handed out.
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(vld) == $past($countones(vld))
              + $past(int'(sample_valid && !sample_stall))
              - $past(int'(result_valid && !result_stall))))
    else $error("pipeline dropped or duplicated an item");

  // Table values stay inside the symmetric Q15 range.
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> ((sn2 != q15_t'(Q15_MIN)) && (cs2 != q15_t'(Q15_MIN))))
    else $error("sine or cosine outside the Q15 range");
`endif

endmodule

`default_nettype wire
